// File: rtl/core/ttim_pkg.sv
// Shared types and constants for the triple timer with interrupt request.
`default_nettype none

package ttim_pkg;

    // Operation codes as they arrive on the input stream.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register offsets.
    localparam logic [2:0] ADDR_CTRL    = 3'd0;
    localparam logic [2:0] ADDR_STATUS  = 3'd1;
    localparam logic [2:0] ADDR_T1_MSB  = 3'd2;
    localparam logic [2:0] ADDR_T1_LSB  = 3'd3;
    localparam logic [2:0] ADDR_T2_MSB  = 3'd4;
    localparam logic [2:0] ADDR_T2_LSB  = 3'd5;
    localparam logic [2:0] ADDR_T3_MSB  = 3'd6;
    localparam logic [2:0] ADDR_T3_LSB  = 3'd7;

    // Control and status bit positions.
    localparam int CTL1_HOLD_BIT   = 0;
    localparam int CTL2_SEL_BIT    = 0;
    localparam int CTL2_IRQ_EN_BIT = 6;
    localparam int ST_IRQ_BIT      = 7;
    localparam int ST_T2_BIT       = 1;

    localparam logic [15:0] COUNT_RESET = 16'hFFFF;
    localparam int          NUM_TIMERS  = 3;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  addr;
        logic [7:0]  wdata;
        logic [15:0] cycles;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/triple_timer_with_irq_unit.sv
// Top level of the triple timer with interrupt request.
// Usage:
//   Input stream (i_s_*): one item per tick, register read or register write.
//   i_s_tuser carries the operation, i_s_tdata the address, write byte and
//   elapsed cycle count. Output stream (o_m_*): exactly one result per item,
//   in order, holding the read byte, the interrupt level after the item and
//   the overrun flag for counter 2.
// An accepted item is written into the command queue, then executed from the
//   queue into the output register, where the receiver takes its result.
// Throughput: one item per cycle while results are taken; a tick is a
//   subtract, an add and compares on counter 2 in the execution stage.
// The front end classifies items into a two-entry command queue; the back
//   end executes one command per cycle into an output register, unless stalled.
// Stall: when the receiver holds i_m_tready low the result stays in place,
//   the queue fills with up to two more items, and then o_s_tready drops.
// Reset (synchronous, active low): counters and reload latches go to 0xFFFF,
//   control, status, the clear arming and the interrupt go to zero, and the
//   queue and output register empty.
`default_nettype none

module triple_timer_with_irq_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata: reg_address[2:0], write_byte[10:3], elapsed_cycles[26:11], zeros
    input  wire logic [ttim_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: operation[1:0]
    input  wire logic [ttim_pkg::IN_USER_W-1:0]     i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata: read_byte[7:0], irq_level[8], overrun_error[9], zeros
    output logic [ttim_pkg::OUT_DATA_W-1:0]         o_m_tdata
);

    ttim_pkg::t_cmd w_front_cmd;
    ttim_pkg::t_cmd w_queue_cmd;
    logic           w_full;
    logic           w_push;
    logic           w_cmd_valid;
    logic           w_cmd_ready;

    assign o_s_tready = !w_full;
    assign w_push     = i_s_tvalid && !w_full;

    ttim_front u_front (
        .i_op   (i_s_tuser),
        .i_data (i_s_tdata),
        .o_cmd  (w_front_cmd)
    );

    ttim_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_front_cmd),
        .o_full     (w_full),
        .o_valid    (w_cmd_valid),
        .o_cmd      (w_queue_cmd),
        .i_pop      (w_cmd_valid && w_cmd_ready)
    );

    ttim_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_queue_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/ttim_front.sv
// Front end: unpacks an input item and classifies it into a command.
`default_nettype none

module ttim_front (
    input  wire logic [ttim_pkg::IN_USER_W-1:0] i_op,
    input  wire logic [ttim_pkg::IN_DATA_W-1:0] i_data,
    output ttim_pkg::t_cmd                      o_cmd
);

    always_comb begin
        o_cmd        = '0;
        o_cmd.addr   = i_data[2:0];
        o_cmd.wdata  = i_data[10:3];
        o_cmd.cycles = i_data[26:11];
        case (i_op)
            ttim_pkg::OP_TICK: begin
                o_cmd.kind  = ttim_pkg::KIND_TICK;
                o_cmd.addr  = '0;
                o_cmd.wdata = '0;
            end
            ttim_pkg::OP_READ: begin
                o_cmd.kind   = ttim_pkg::KIND_READ;
                o_cmd.wdata  = '0;
                o_cmd.cycles = '0;
            end
            ttim_pkg::OP_WRITE: begin
                o_cmd.kind   = ttim_pkg::KIND_WRITE;
                o_cmd.cycles = '0;
            end
            default: begin
                // The unused operation code passes through as a no-op.
                o_cmd = '0;
                o_cmd.kind = ttim_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ttim_queue.sv
// Two-entry command queue between the front end and the execution back end.
`default_nettype none

module ttim_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ttim_pkg::t_cmd i_push_cmd,
    output logic                o_full,
    output logic                o_valid,
    output ttim_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);

    ttim_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("command queue count out of range");

endmodule

`default_nettype wire

// File: rtl/core/ttim_back.sv
// Back end: timer state, register access and the output result register.
`default_nettype none

module ttim_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cmd_valid,
    input  wire ttim_pkg::t_cmd                  i_cmd,
    output logic                                 o_cmd_ready,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [ttim_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    logic [15:0] r_c1, n_c1;
    logic [15:0] r_c2, n_c2;
    logic [15:0] r_c3, n_c3;
    logic [15:0] r_latch [ttim_pkg::NUM_TIMERS];
    logic [15:0] n_latch [ttim_pkg::NUM_TIMERS];
    logic [7:0]  r_ctl1, n_ctl1;
    logic [7:0]  r_ctl2, n_ctl2;
    logic [7:0]  r_ctl3, n_ctl3;
    logic [7:0]  r_status, n_status;
    logic        r_armed, n_armed;
    logic        r_irq, n_irq;

    logic        r_out_valid, n_out_valid;
    logic [ttim_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic               w_exec;
    logic signed [17:0] w_diff;
    logic signed [17:0] w_sum;
    logic [7:0]         w_rd;
    logic               w_err;
    logic               w_st_set;
    logic [1:0]         w_idx;

    assign o_cmd_ready = !r_out_valid || i_m_tready;
    assign w_exec      = i_cmd_valid && o_cmd_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Counter 2 is kept non-negative, so 18 signed bits hold both steps.
    assign w_diff = $signed({2'b00, r_c2}) - $signed({2'b00, i_cmd.cycles});
    assign w_sum  = w_diff + $signed({2'b00, r_latch[1]});
    assign w_st_set = r_status[ttim_pkg::ST_IRQ_BIT] && r_status[ttim_pkg::ST_T2_BIT];
    assign w_idx  = 2'((i_cmd.addr - 3'd2) >> 1);

    always_comb begin
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_c3     = r_c3;
        n_latch  = r_latch;
        n_ctl1   = r_ctl1;
        n_ctl2   = r_ctl2;
        n_ctl3   = r_ctl3;
        n_status = r_status;
        n_armed  = r_armed;
        n_irq    = r_irq;
        w_rd     = '0;
        w_err    = 1'b0;
        if (w_exec) begin
            case (i_cmd.kind)
                ttim_pkg::KIND_TICK: begin
                    if (!r_ctl1[ttim_pkg::CTL1_HOLD_BIT]) begin
                        n_c1 = r_c1 - i_cmd.cycles;
                        n_c3 = r_c3 - i_cmd.cycles;
                        n_c2 = w_diff[15:0];
                        if (w_diff <= 18'sd0) begin
                            if (r_ctl2[ttim_pkg::CTL2_IRQ_EN_BIT]) begin
                                n_irq = 1'b1;
                                n_status[ttim_pkg::ST_IRQ_BIT] = 1'b1;
                                n_status[ttim_pkg::ST_T2_BIT]  = 1'b1;
                            end
                        end
                        if (w_diff < 18'sd0) begin
                            if (r_latch[1] == 16'd0) begin
                                n_c2 = '0;
                            end else if (w_sum < 18'sd0) begin
                                n_c2  = '0;
                                w_err = 1'b1;
                            end else begin
                                n_c2 = w_sum[15:0];
                            end
                        end
                    end
                end
                ttim_pkg::KIND_READ: begin
                    case (i_cmd.addr)
                        ttim_pkg::ADDR_STATUS: begin
                            if (w_st_set) begin
                                n_armed = 1'b1;
                            end
                            w_rd = r_status;
                        end
                        ttim_pkg::ADDR_T1_MSB: w_rd = r_c1[15:8];
                        ttim_pkg::ADDR_T1_LSB: w_rd = r_c1[7:0];
                        ttim_pkg::ADDR_T2_MSB: w_rd = r_c2[15:8];
                        ttim_pkg::ADDR_T2_LSB: begin
                            // Status read followed by this read acknowledges the interrupt.
                            if (r_armed && w_st_set) begin
                                n_irq   = 1'b0;
                                n_armed = 1'b0;
                                n_status[ttim_pkg::ST_IRQ_BIT] = 1'b0;
                                n_status[ttim_pkg::ST_T2_BIT]  = 1'b0;
                            end
                            w_rd = r_c2[7:0];
                        end
                        ttim_pkg::ADDR_T3_MSB: w_rd = r_c3[15:8];
                        ttim_pkg::ADDR_T3_LSB: w_rd = r_c3[7:0];
                        default: w_rd = '0;
                    endcase
                end
                ttim_pkg::KIND_WRITE: begin
                    case (i_cmd.addr)
                        ttim_pkg::ADDR_CTRL: begin
                            if (r_ctl2[ttim_pkg::CTL2_SEL_BIT]) begin
                                n_ctl1 = i_cmd.wdata;
                            end else begin
                                n_ctl3 = i_cmd.wdata;
                            end
                        end
                        ttim_pkg::ADDR_STATUS: n_ctl2 = i_cmd.wdata;
                        default: begin
                            if (i_cmd.addr[0]) begin
                                n_latch[w_idx][7:0] = i_cmd.wdata;
                            end else begin
                                n_latch[w_idx][15:8] = i_cmd.wdata;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (w_exec) begin
            n_out_valid = 1'b1;
            n_out_data  = {6'b0, w_err, n_irq, w_rd};
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1        <= ttim_pkg::COUNT_RESET;
            r_c2        <= ttim_pkg::COUNT_RESET;
            r_c3        <= ttim_pkg::COUNT_RESET;
            r_latch     <= '{default: ttim_pkg::COUNT_RESET};
            r_ctl1      <= '0;
            r_ctl2      <= '0;
            r_ctl3      <= '0;
            r_status    <= '0;
            r_armed     <= 1'b0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_c1        <= n_c1;
            r_c2        <= n_c2;
            r_c3        <= n_c3;
            r_latch     <= n_latch;
            r_ctl1      <= n_ctl1;
            r_ctl2      <= n_ctl2;
            r_ctl3      <= n_ctl3;
            r_status    <= n_status;
            r_armed     <= n_armed;
            r_irq       <= n_irq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    a_irq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq |-> (r_status[ttim_pkg::ST_IRQ_BIT] && r_status[ttim_pkg::ST_T2_BIT]))
        else $error("interrupt pending without status bits");

    a_armed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_status[ttim_pkg::ST_IRQ_BIT] && r_status[ttim_pkg::ST_T2_BIT]))
        else $error("clear armed without status bits");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result was lost or changed");

endmodule

`default_nettype wire

// File: tb/triple_timer_with_irq_unit_tb.sv
// Self-checking testbench for the triple timer with interrupt request.
`default_nettype none

module triple_timer_with_irq_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttim_pkg::*;

    typedef struct packed {
        logic       overrun;
        logic       irq;
        logic [7:0] rbyte;
    } timer_result_t;

    logic i_clk = 1'b1;
    logic i_rst_n = 1'b0;

    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [IN_USER_W-1:0]  s_user = '0;
    logic                  m_ready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    triple_timer_with_irq_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Predicted timer state.
    logic [15:0] count1 = COUNT_RESET;
    int          count2 = int'(COUNT_RESET);
    logic [15:0] count3 = COUNT_RESET;
    logic [15:0] reload [NUM_TIMERS] = '{COUNT_RESET, COUNT_RESET, COUNT_RESET};
    logic [7:0]  cr1 = '0;
    logic [7:0]  cr2 = '0;
    logic [7:0]  cr3 = '0;
    logic [7:0]  status_reg = '0;
    logic        clear_armed = 1'b0;
    logic        irq_line = 1'b0;

    t_cmd          bus_items [$];
    timer_result_t results_due [$];

    bit item_taken = 1'b0;
    bit calm = 1'b0;
    bit long_hold_done = 1'b0;
    int results_seen = 0;
    int mismatches = 0;
    int send_gap = 0;
    int hold_left = 0;

    task automatic timer_advance(input t_cmd c, output timer_result_t r);
        logic [15:0] c2;
        r = '0;
        c2 = count2[15:0];
        case (c.kind)
            KIND_TICK: begin
                if (!cr1[CTL1_HOLD_BIT]) begin
                    count1 = count1 - c.cycles;
                    count3 = count3 - c.cycles;
                    count2 = count2 - int'(c.cycles);
                    if (count2 <= 0) begin
                        if (cr2[CTL2_IRQ_EN_BIT]) begin
                            irq_line = 1'b1;
                            status_reg[ST_IRQ_BIT] = 1'b1;
                            status_reg[ST_T2_BIT] = 1'b1;
                        end
                        if (count2 < 0) begin
                            if (reload[1] != 16'd0) begin
                                count2 = count2 + int'(reload[1]);
                                if (count2 < 0) begin
                                    count2 = 0;
                                    r.overrun = 1'b1;
                                end
                            end else begin
                                count2 = 0;
                            end
                        end
                    end
                end
            end
            KIND_READ: begin
                case (c.addr)
                    ADDR_STATUS: begin
                        if (status_reg[ST_IRQ_BIT] && status_reg[ST_T2_BIT])
                            clear_armed = 1'b1;
                        r.rbyte = status_reg;
                    end
                    ADDR_T1_MSB: r.rbyte = count1[15:8];
                    ADDR_T1_LSB: r.rbyte = count1[7:0];
                    ADDR_T2_MSB: r.rbyte = c2[15:8];
                    ADDR_T2_LSB: begin
                        // Reading the low byte after an armed status read drops the request.
                        if (clear_armed && status_reg[ST_IRQ_BIT] && status_reg[ST_T2_BIT]) begin
                            irq_line = 1'b0;
                            clear_armed = 1'b0;
                            status_reg[ST_IRQ_BIT] = 1'b0;
                            status_reg[ST_T2_BIT] = 1'b0;
                        end
                        r.rbyte = c2[7:0];
                    end
                    ADDR_T3_MSB: r.rbyte = count3[15:8];
                    ADDR_T3_LSB: r.rbyte = count3[7:0];
                    default: r.rbyte = 8'd0;
                endcase
            end
            KIND_WRITE: begin
                case (c.addr)
                    ADDR_CTRL: begin
                        if (cr2[CTL2_SEL_BIT])
                            cr1 = c.wdata;
                        else
                            cr3 = c.wdata;
                    end
                    ADDR_STATUS: cr2 = c.wdata;
                    ADDR_T1_MSB: reload[0][15:8] = c.wdata;
                    ADDR_T1_LSB: reload[0][7:0] = c.wdata;
                    ADDR_T2_MSB: reload[1][15:8] = c.wdata;
                    ADDR_T2_LSB: reload[1][7:0] = c.wdata;
                    ADDR_T3_MSB: reload[2][15:8] = c.wdata;
                    default: reload[2][7:0] = c.wdata;
                endcase
            end
            default: ;
        endcase
        r.irq = irq_line;
    endtask

    function automatic t_cmd make_cmd(t_kind k, logic [2:0] a, logic [7:0] d, logic [15:0] n);
        t_cmd c;
        c.kind = k;
        c.addr = a;
        c.wdata = d;
        c.cycles = n;
        return c;
    endfunction

    task automatic note_bad(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_seen, field, want, got);
    endtask

    // Input side: items change at the falling edge; an offered item stays until taken.
    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n && (!s_valid || item_taken)) begin
            calm = (bus_items.size() < 60);
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (bus_items.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 4);
                s_valid <= 1'b0;
            end else begin
                c = bus_items.pop_front();
                s_valid <= 1'b1;
                s_data <= {5'd0, c.cycles, c.wdata, c.addr};
                s_user <= c.kind;
            end
        end
    end

    // Output side: random short stalls, plus one long hold-off that backs up the block.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 150) begin
                long_hold_done = 1'b1;
                hold_left = 59;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cmd          c;
        timer_result_t want;
        timer_result_t got;
        item_taken = 1'b0;
        if (i_rst_n) begin
            // Check the outgoing result before predicting the item taken on this edge.
            if (o_m_tvalid && m_ready) begin
                got = o_m_tdata[9:0];
                if (results_due.size() == 0) begin
                    note_bad("unexpected result", 0, got);
                end else begin
                    want = results_due.pop_front();
                    if (got.rbyte !== want.rbyte)
                        note_bad("read_byte", want.rbyte, got.rbyte);
                    if (got.irq !== want.irq)
                        note_bad("irq_level", want.irq, got.irq);
                    if (got.overrun !== want.overrun)
                        note_bad("overrun_error", want.overrun, got.overrun);
                end
                results_seen++;
            end
            if (s_valid && o_s_tready) begin
                c.kind = t_kind'(s_user);
                c.addr = s_data[2:0];
                c.wdata = s_data[10:3];
                c.cycles = s_data[26:11];
                timer_advance(c, want);
                results_due.push_back(want);
                item_taken = 1'b1;
            end
        end
    end

    initial begin
        int       pick;
        int       a;
        logic [7:0] d;
        logic [15:0] n;

        for (int i = 0; i < 8; i++)
            bus_items.push_back(make_cmd(KIND_READ, 3'(i), 8'h00, 16'h0000));
        // Stop the counters through control 1, then let them run again.
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_STATUS, 8'h41, 16'h0000));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_CTRL, 8'h01, 16'h0000));
        bus_items.push_back(make_cmd(KIND_TICK, 3'd0, 8'h00, 16'hFFFF));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_CTRL, 8'h00, 16'h0000));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_STATUS, 8'h40, 16'h0000));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_CTRL, 8'hA5, 16'h0000));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_T2_MSB, 8'h00, 16'h0000));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_T2_LSB, 8'h10, 16'h0000));
        // Counter 2 reaches zero exactly, stays there on a zero tick, then reloads.
        bus_items.push_back(make_cmd(KIND_TICK, 3'd0, 8'h00, 16'hFFFF));
        bus_items.push_back(make_cmd(KIND_READ, ADDR_STATUS, 8'h00, 16'h0000));
        bus_items.push_back(make_cmd(KIND_TICK, 3'd0, 8'h00, 16'h0000));
        bus_items.push_back(make_cmd(KIND_TICK, 3'd0, 8'h00, 16'h0005));
        // Too large a tick for the small reload value: overrun.
        bus_items.push_back(make_cmd(KIND_TICK, 3'd0, 8'h00, 16'hFFFF));
        bus_items.push_back(make_cmd(KIND_READ, ADDR_T2_MSB, 8'h00, 16'h0000));
        bus_items.push_back(make_cmd(KIND_READ, ADDR_T2_LSB, 8'h00, 16'h0000));
        bus_items.push_back(make_cmd(KIND_READ, ADDR_STATUS, 8'h00, 16'h0000));
        // A zero reload value holds counter 2 at zero.
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_T2_LSB, 8'h00, 16'h0000));
        bus_items.push_back(make_cmd(KIND_TICK, 3'd0, 8'h00, 16'd100));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_T1_MSB, 8'hFF, 16'h0000));
        bus_items.push_back(make_cmd(KIND_WRITE, ADDR_T3_LSB, 8'h34, 16'h0000));
        bus_items.push_back(make_cmd(KIND_NOP, 3'd7, 8'hFF, 16'hFFFF));
        bus_items.push_back(make_cmd(KIND_READ, ADDR_T3_LSB, 8'h00, 16'h0000));

        while (bus_items.size() < 580) begin
            pick = $urandom_range(0, 99);
            a = $urandom_range(0, 7);
            d = 8'($urandom);
            if ($urandom_range(0, 2) == 0)
                n = 16'($urandom_range(0, 64));
            else if ($urandom_range(0, 1) == 0)
                n = 16'($urandom_range(0, 4095));
            else
                n = 16'($urandom);
            if (pick < 40) begin
                bus_items.push_back(make_cmd(KIND_TICK, 3'(a), d, n));
            end else if (pick < 55) begin
                // The clearing sequence: status first, then the timer 2 low byte.
                bus_items.push_back(make_cmd(KIND_READ, ADDR_STATUS, d, n));
                if ($urandom_range(0, 3) == 0)
                    bus_items.push_back(make_cmd(KIND_TICK, 3'(a), d, n));
                bus_items.push_back(make_cmd(KIND_READ, ADDR_T2_LSB, 8'($urandom), n));
            end else if (pick < 70) begin
                bus_items.push_back(make_cmd(KIND_READ, 3'(a), d, n));
            end else if (pick < 95) begin
                // Keep the counters running most of the time.
                if (3'(a) == ADDR_CTRL && $urandom_range(0, 3) != 0)
                    d[CTL1_HOLD_BIT] = 1'b0;
                bus_items.push_back(make_cmd(KIND_WRITE, 3'(a), d, n));
            end else begin
                bus_items.push_back(make_cmd(KIND_NOP, 3'(a), d, n));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bus_items.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
